FILE: hw/rtl/mep_pkg.sv
// shared types, constants and color table builders for the mandelbrot escape pixel block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

    localparam int IMAGE_SIDE        = 4096;
    localparam int COLOR_TABLE_DEPTH = 1024;
    localparam int COLOR_IDX_W       = $clog2(COLOR_TABLE_DEPTH);

    localparam int COORD_W  = 12;
    localparam int COUNT_W  = 10;
    localparam int COLOR_W  = 8;
    localparam int ORIGIN_W = 60;
    localparam int STEP_W   = 56;
    localparam int FRAC_W   = 56;
    // z components stay inside +-16, so 61 bits signed and 60 bits of magnitude
    localparam int Z_W      = 61;
    localparam int MAG_W    = 60;
    localparam int HALF_W   = MAG_W / 2;
    localparam int PROD_W   = 2 * HALF_W;
    localparam int ACC_W    = 2 * MAG_W;
    localparam int MAP_W    = STEP_W + COORD_W;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    localparam logic [COUNT_W-1:0] MAX_LIMIT = 10'd1022;

    localparam logic signed [ORIGIN_W-1:0] ORIGIN_REAL_RST = 60'sd25716490621008025;
    localparam logic signed [ORIGIN_W-1:0] ORIGIN_IMAG_RST = -60'sd46506763825613107;
    localparam logic [STEP_W-1:0]          PIXEL_STEP_RST  = 56'd576460752;
    localparam logic [COUNT_W-1:0]         ITER_LIMIT_RST  = 10'd880;

    localparam int              COLOR_OFFSET = 80;
    localparam int              COLOR_SPAN   = 800;
    localparam longint unsigned SPAN_CUBE    = 64'd512000000;

    typedef enum logic [1:0] {
        REG_ORIGIN_REAL,
        REG_ORIGIN_IMAG,
        REG_PIXEL_STEP,
        REG_ITER_LIMIT
    } reg_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_RE,
        ST_MAP_IM,
        ST_MAP_END,
        ST_MAG,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ACC,
        ST_CHECK,
        ST_ROM_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [ORIGIN_W-1:0] origin_real;
        logic signed [ORIGIN_W-1:0] origin_imag;
        logic [STEP_W-1:0]          pixel_step;
        logic [COUNT_W-1:0]         iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       map_re;
        logic       map_im;
        logic       init;
        logic       mag;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       acc_en;
        logic       update;
        logic       count;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
        logic out_free;
    } status_t;

    typedef logic [3*COLOR_W-1:0] color_rom_t [COLOR_TABLE_DEPTH];

    // largest k with k^10 * 800^7 <= 255^10 * m^7
    function automatic logic [COLOR_W-1:0] green_of(longint unsigned m);
        logic [159:0] rhs;
        logic [159:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = 160'd1;
        for (int i = 0; i < 10; i++)
            rhs = rhs * 160'd255;
        for (int i = 0; i < 7; i++)
            rhs = rhs * 160'(m);
        lo = 0;
        hi = 254;
        for (int s = 0; s < 9; s++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = 160'd1;
                for (int i = 0; i < 10; i++)
                    lhs = lhs * 160'(mid);
                for (int i = 0; i < 7; i++)
                    lhs = lhs * 160'd800;
                if (lhs <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
        end
        return COLOR_W'(lo);
    endfunction

    // {red, green, blue} for one escape count
    function automatic logic [3*COLOR_W-1:0] color_entry(int unsigned n);
        longint unsigned    m;
        longint unsigned    red;
        longint unsigned    blue;
        logic [COLOR_W-1:0] green;
        if (n < COLOR_OFFSET)
            return '0;
        m = longint'(n) - COLOR_OFFSET;
        if (m >= COLOR_SPAN)
            return '1;
        red  = (64'd255 * m * m * m) / SPAN_CUBE;
        blue = 0;
        for (int k = 0; k < 254; k++) begin
            if (blue < 254 && (blue + 1) * (blue + 1) * 64'd800 <= 64'd65025 * m)
                blue = blue + 1;
        end
        green = green_of(m);
        return {COLOR_W'(red), green, COLOR_W'(blue)};
    endfunction

    function automatic color_rom_t build_color_rom();
        color_rom_t rom;
        for (int n = 0; n < COLOR_TABLE_DEPTH; n++)
            rom[n] = color_entry(n);
        return rom;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mep_color_rom.sv
// color lookup rom: escape count to red, green and blue, registered read
// depends on mep_pkg for the table builder
`timescale 1ns / 1ps
`default_nettype none

module mep_color_rom (
    input  wire logic                            clk,
    input  wire logic [mep_pkg::COUNT_W-1:0]     count,
    output logic      [3*mep_pkg::COLOR_W-1:0]   rgb
);
    import mep_pkg::*;

    localparam color_rom_t COLOR_ROM = build_color_rom();

    logic [COLOR_IDX_W-1:0] idx;

    // counts past the table read its last entry
    assign idx = (32'(count) >= 32'(COLOR_TABLE_DEPTH)) ?
                 COLOR_IDX_W'(COLOR_TABLE_DEPTH - 1) : COLOR_IDX_W'(count);

    always_ff @(posedge clk)
    begin
        rgb <= COLOR_ROM[idx];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mep_datapath.sv
// datapath: point mapping, z = z^2 + c iteration with three 30x30 multipliers,
// escape test, count and output register; depends on mep_pkg and mep_color_rom
`timescale 1ns / 1ps
`default_nettype none

module mep_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mep_pkg::cfg_t                 cfg,
    input  wire logic [mep_pkg::COORD_W-1:0]   column,
    input  wire logic [mep_pkg::COORD_W-1:0]   row,
    input  wire logic                          out_ready,
    input  wire mep_pkg::cmd_t                 cmd,
    output mep_pkg::status_t                   status,
    output logic                               out_valid,
    output logic [mep_pkg::COLOR_W-1:0]        red,
    output logic [mep_pkg::COLOR_W-1:0]        green,
    output logic [mep_pkg::COLOR_W-1:0]        blue,
    output logic [mep_pkg::COUNT_W-1:0]        escape_count
);
    import mep_pkg::*;

    // a square below four needs 58 bits at Q.56
    localparam int SQ_W    = FRAC_W + 2;
    localparam int ESC_BIT = FRAC_W + SQ_W;

    logic [COORD_W-1:0]        col_reg;
    logic [COORD_W-1:0]        row_reg;
    logic [COORD_W-1:0]        col_clamp;
    logic [COORD_W-1:0]        row_clamp;
    logic [MAP_W-1:0]          mprod_reg;
    logic signed [ORIGIN_W-1:0] cr_reg;
    logic signed [ORIGIN_W-1:0] ci_reg;
    logic signed [Z_W-1:0]     a_reg;
    logic signed [Z_W-1:0]     b_reg;
    logic signed [Z_W-1:0]     a_next;
    logic signed [Z_W-1:0]     b_next;
    logic [MAG_W-1:0]          ma_reg;
    logic [MAG_W-1:0]          mb_reg;
    logic                      neg_reg;
    logic [1:0]                sh_reg;
    logic [PROD_W-1:0]         prod_aa_reg;
    logic [PROD_W-1:0]         prod_bb_reg;
    logic [PROD_W-1:0]         prod_ab_reg;
    logic [ACC_W-1:0]          acc_aa_reg;
    logic [ACC_W-1:0]          acc_bb_reg;
    logic [ACC_W-1:0]          acc_ab_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic [COUNT_W-1:0]        lim;
    logic [SQ_W-1:0]           sa;
    logic [SQ_W-1:0]           sb;
    logic [SQ_W:0]             sum_sq;
    logic [SQ_W:0]             p_ab;
    logic [3*COLOR_W-1:0]      rom_rgb;
    logic                      out_valid_reg;
    logic [COLOR_W-1:0]        red_reg;
    logic [COLOR_W-1:0]        green_reg;
    logic [COLOR_W-1:0]        blue_reg;
    logic [COUNT_W-1:0]        count_reg;

    function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v);
        if (32'(v) >= 32'(IMAGE_SIDE))
            return COORD_W'(IMAGE_SIDE - 1);
        return v;
    endfunction

    // origin + offset, saturated to the signed Q4.56 range
    function automatic logic signed [ORIGIN_W-1:0] to_point(logic [ORIGIN_W-1:0] origin,
                                                            logic [MAP_W-1:0] off);
        logic [ORIGIN_W-1:0] biased;
        logic [MAP_W:0]      sum;
        logic [ORIGIN_W-1:0] sat;
        biased = {~origin[ORIGIN_W-1], origin[ORIGIN_W-2:0]};
        sum    = (MAP_W+1)'(biased) + (MAP_W+1)'(off);
        sat    = (|sum[MAP_W:ORIGIN_W]) ? {ORIGIN_W{1'b1}} : sum[ORIGIN_W-1:0];
        return {~sat[ORIGIN_W-1], sat[ORIGIN_W-2:0]};
    endfunction

    function automatic logic [HALF_W-1:0] half(logic [MAG_W-1:0] v, logic hi);
        return hi ? v[MAG_W-1:HALF_W] : v[HALF_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] place(logic [PROD_W-1:0] p, logic [1:0] sh);
        logic [ACC_W-1:0] w;
        w = ACC_W'(p);
        case (sh)
            2'd0:    return w;
            2'd1:    return w << HALF_W;
            2'd2:    return w << (2 * HALF_W);
            default: return w;
        endcase
    endfunction

    assign col_clamp = clamp_coord(column);
    assign row_clamp = clamp_coord(row);

    assign lim = (cfg.iteration_limit > MAX_LIMIT) ? MAX_LIMIT : cfg.iteration_limit;

    assign sa     = acc_aa_reg[ESC_BIT-1:FRAC_W];
    assign sb     = acc_bb_reg[ESC_BIT-1:FRAC_W];
    assign sum_sq = {1'b0, sa} + {1'b0, sb};
    // 2ab at Q.56, only used once both squares are below four
    assign p_ab   = acc_ab_reg[ESC_BIT-1:FRAC_W-1];

    assign a_next = Z_W'(sa) - Z_W'(sb) + Z_W'(cr_reg);
    assign b_next = (neg_reg ? -Z_W'(p_ab) : Z_W'(p_ab)) + Z_W'(ci_reg);

    assign status.escape   = (|acc_aa_reg[ACC_W-1:ESC_BIT]) | (|acc_bb_reg[ACC_W-1:ESC_BIT])
                             | sum_sq[SQ_W];
    assign status.at_limit = (n_reg >= lim);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            col_reg <= col_clamp;
            row_reg <= row_clamp;
        end
        if (cmd.map_re || cmd.map_im)
            mprod_reg <= MAP_W'(cfg.pixel_step) * MAP_W'(cmd.map_im ? row_reg : col_reg);
        if (cmd.map_im)
            cr_reg <= to_point(cfg.origin_real, mprod_reg);
        if (cmd.init) begin
            ci_reg <= to_point(cfg.origin_imag, mprod_reg);
            a_reg  <= '0;
            b_reg  <= '0;
            n_reg  <= '0;
        end
        if (cmd.mag) begin
            ma_reg  <= a_reg[Z_W-1] ? MAG_W'(-a_reg) : MAG_W'(a_reg);
            mb_reg  <= b_reg[Z_W-1] ? MAG_W'(-b_reg) : MAG_W'(b_reg);
            neg_reg <= a_reg[Z_W-1] ^ b_reg[Z_W-1];
        end
        // one partial product per multiplier per cycle
        if (cmd.mul_en) begin
            prod_aa_reg <= half(ma_reg, cmd.mul_step[1]) * half(ma_reg, cmd.mul_step[0]);
            prod_bb_reg <= half(mb_reg, cmd.mul_step[1]) * half(mb_reg, cmd.mul_step[0]);
            prod_ab_reg <= half(ma_reg, cmd.mul_step[1]) * half(mb_reg, cmd.mul_step[0]);
            sh_reg      <= 2'(cmd.mul_step[1]) + 2'(cmd.mul_step[0]);
        end
        if (cmd.mag) begin
            acc_aa_reg <= '0;
            acc_bb_reg <= '0;
            acc_ab_reg <= '0;
        end
        else if (cmd.acc_en) begin
            acc_aa_reg <= acc_aa_reg + place(prod_aa_reg, sh_reg);
            acc_bb_reg <= acc_bb_reg + place(prod_bb_reg, sh_reg);
            acc_ab_reg <= acc_ab_reg + place(prod_ab_reg, sh_reg);
        end
        if (cmd.update) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.count)
            n_reg <= n_reg + 1'b1;
        if (cmd.emit) begin
            red_reg   <= rom_rgb[3*COLOR_W-1:2*COLOR_W];
            green_reg <= rom_rgb[2*COLOR_W-1:COLOR_W];
            blue_reg  <= rom_rgb[COLOR_W-1:0];
            count_reg <= n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    mep_color_rom u_color_rom (
        .clk   (clk),
        .count (n_reg),
        .rgb   (rom_rgb)
    );

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign escape_count = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mep_ctrl.sv
// controller state machine: sequences mapping, partial products, escape test and output
// depends on mep_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module mep_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mep_pkg::status_t  status,
    output mep_pkg::cmd_t          cmd
);
    import mep_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_RE;
                end
            end
            ST_MAP_RE:
            begin
                cmd.map_re = 1'b1;
                state_next = ST_MAP_IM;
            end
            ST_MAP_IM:
            begin
                cmd.map_im = 1'b1;
                state_next = ST_MAP_END;
            end
            ST_MAP_END:
            begin
                cmd.init   = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd0;
                state_next   = ST_MUL1;
            end
            // accumulation adds each partial product in the cycle after the multipliers register it
            ST_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd1;
                cmd.acc_en   = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd2;
                cmd.acc_en   = 1'b1;
                state_next   = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd3;
                cmd.acc_en   = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.escape)
                    state_next = ST_ROM_WAIT;
                else if (status.at_limit) begin
                    // never escaped: count ends at limit plus one
                    cmd.count  = 1'b1;
                    state_next = ST_ROM_WAIT;
                end
                else begin
                    cmd.count  = 1'b1;
                    cmd.update = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_ROM_WAIT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mep_cfg.sv
// configuration registers behind the apb-style port
// depends on mep_pkg for the register map and cfg_t
`timescale 1ns / 1ps
`default_nettype none

module mep_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
    output logic      [mep_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output mep_pkg::cfg_t                    cfg
);
    import mep_pkg::*;

    cfg_t      cfg_reg;
    reg_code_t code;
    logic      wr_en;

    // registers sit on 8-byte boundaries
    assign code   = reg_code_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.origin_real     <= ORIGIN_REAL_RST;
            cfg_reg.origin_imag     <= ORIGIN_IMAG_RST;
            cfg_reg.pixel_step      <= PIXEL_STEP_RST;
            cfg_reg.iteration_limit <= ITER_LIMIT_RST;
        end
        else if (wr_en) begin
            case (code)
                REG_ORIGIN_REAL: cfg_reg.origin_real     <= pwdata[ORIGIN_W-1:0];
                REG_ORIGIN_IMAG: cfg_reg.origin_imag     <= pwdata[ORIGIN_W-1:0];
                REG_PIXEL_STEP:  cfg_reg.pixel_step      <= pwdata[STEP_W-1:0];
                REG_ITER_LIMIT:  cfg_reg.iteration_limit <= pwdata[COUNT_W-1:0];
                default:         cfg_reg.iteration_limit <= cfg_reg.iteration_limit;
            endcase
        end
    end

    always_comb
    begin
        case (code)
            REG_ORIGIN_REAL: prdata = DATA_W'(cfg_reg.origin_real);
            REG_ORIGIN_IMAG: prdata = DATA_W'(cfg_reg.origin_imag);
            REG_PIXEL_STEP:  prdata = DATA_W'(cfg_reg.pixel_step);
            REG_ITER_LIMIT:  prdata = DATA_W'(cfg_reg.iteration_limit);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_pixel_top.sv
// mandelbrot escape pixel top: mep_cfg, mep_ctrl and mep_datapath over mep_pkg
// sequence: mapping of the point, then per escape test the magnitudes, the four partial-product
// steps of the three 30x30 multipliers, the last accumulation and the check, then the color
// lookup in the registered color rom and the load of the output registers
// throughput: one pixel at a time, next input transfer in the cycle after the result is loaded
// reset: asynchronous active low, clears the controller and output valid, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_pixel_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mep_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mep_pkg::DATA_W-1:0]    pwdata,
    output logic      [mep_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mep_pkg::COORD_W-1:0]   column,
    input  wire logic [mep_pkg::COORD_W-1:0]   row,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [mep_pkg::COLOR_W-1:0]   red,
    output logic      [mep_pkg::COLOR_W-1:0]   green,
    output logic      [mep_pkg::COLOR_W-1:0]   blue,
    output logic      [mep_pkg::COUNT_W-1:0]   escape_count
);
    import mep_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    mep_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mep_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .column       (column),
        .row          (row),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .escape_count (escape_count)
    );

endmodule

`default_nettype wire
